// ----- rtl/core/inverse_trig_continued_fraction_defines.svh -----
// Assertion macros for the inverse trigonometric unit.
// Included by the top level; uses its clk and rst_n.
`ifndef INVERSE_TRIG_CONTINUED_FRACTION_DEFINES_SVH
`define INVERSE_TRIG_CONTINUED_FRACTION_DEFINES_SVH
`ifndef SYNTH
`define ITCF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("itcf same-cycle check failed");
`define ITCF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("itcf next-cycle check failed");
`else
`define ITCF_ASSERT_IMPL(lbl, ante, cons)
`define ITCF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/core/itcf_pkg.sv -----
// Shared types and constants of the inverse trigonometric unit.
// Has no dependencies; used by every module of the block but itcf_div.
`default_nettype none
package itcf_pkg;
  typedef enum logic [1:0] {
    FN_ATAN  = 2'd0,
    FN_ATAN2 = 2'd1,
    FN_ASIN  = 2'd2,
    FN_ACOS  = 2'd3
  } func_t;

  typedef struct packed {
    func_t func;
    logic  x_neg;
    logic  y_neg;
    logic  x_zero;
    logic  y_zero;
    logic  c_zero;
    logic  fold;
  } ctl_t;

  localparam int TERMS_DEF = 24;
  localparam int OPND_W    = 32;
  localparam int T_W       = 31;
  localparam int S_W       = 27;
  localparam int C_W       = 31;
  localparam int U_W       = 31;
  localparam int R_W       = 30;
  localparam int CF_NUM_W  = 37;
  localparam int CF_DEN_W  = 34;
  localparam int FRAC_C    = 26;
  localparam int SQ_V_W    = 63;
  localparam int SQ_STEPS  = 32;
  localparam int ANG_W     = 34;

  localparam logic [OPND_W-1:0] ONE_Q16 = 32'd65536;
  localparam logic signed [ANG_W-1:0] PI_Q29      = 34'sd1686629713;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q29 = 34'sd843314856;
endpackage
`default_nettype wire

// ----- rtl/core/itcf_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Uses no package items; instantiated by the term and top modules.
`default_nettype none
module itcf_div #(
  parameter int NUM_W  = 62,
  parameter int DEN_W  = 32,
  parameter int Q_W    = 31,
  parameter int SIDE_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire logic              in_valid,
  input  wire logic [NUM_W-1:0]  in_num,
  input  wire logic [DEN_W-1:0]  in_den,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  output logic [Q_W-1:0]         out_q,
  output logic [SIDE_W-1:0]      out_side
);
  localparam int W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic              valid_r [Q_W];
  logic [W-1:0]      rem_r   [Q_W];
  logic [DEN_W-1:0]  den_r   [Q_W];
  logic [Q_W-1:0]    q_r     [Q_W];
  logic [SIDE_W-1:0] side_r  [Q_W];

  for (genvar g = 0; g < Q_W; g++) begin : g_stage
    logic              v_in;
    logic [W-1:0]      rem_in;
    logic [DEN_W-1:0]  den_in;
    logic [Q_W-1:0]    q_in;
    logic [SIDE_W-1:0] side_in;
    logic [W-1:0]      trial;
    logic              take;
    logic [W-1:0]      rem_nxt;

    if (g == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = W'(in_num);
      assign den_in  = in_den;
      assign q_in    = '0;
      assign side_in = in_side;
    end else begin : g_rest
      assign v_in    = valid_r[g-1];
      assign rem_in  = rem_r[g-1];
      assign den_in  = den_r[g-1];
      assign q_in    = q_r[g-1];
      assign side_in = side_r[g-1];
    end

    assign trial   = W'(den_in) << (Q_W - 1 - g);
    assign take    = rem_in >= trial;
    assign rem_nxt = take ? rem_in - trial : rem_in;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[g] <= 1'b0;
      end else if (adv) begin
        valid_r[g] <= v_in;
      end
      if (adv) begin
        rem_r[g]  <= rem_nxt;
        den_r[g]  <= den_in;
        q_r[g]    <= {q_in[Q_W-2:0], take};
        side_r[g] <= side_in;
      end
    end
  end

  assign out_valid = valid_r[Q_W-1];
  assign out_q     = q_r[Q_W-1];
  assign out_side  = side_r[Q_W-1];
endmodule
`default_nettype wire

// ----- rtl/core/itcf_sqrt.sv -----
// Pipelined integer square root, two radicand bits per stage, with sideband.
// Depends on itcf_pkg for widths.
`default_nettype none
module itcf_sqrt #(
  parameter int SIDE_W = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       adv,
  input  wire logic                       in_valid,
  input  wire logic [itcf_pkg::SQ_V_W-1:0] in_rad,
  input  wire logic [SIDE_W-1:0]          in_side,
  output logic                            out_valid,
  output logic [itcf_pkg::C_W-1:0]        out_root,
  output logic [SIDE_W-1:0]               out_side
);
  localparam int VW = itcf_pkg::SQ_V_W;
  localparam int N  = itcf_pkg::SQ_STEPS;

  logic              valid_r [N];
  logic [VW-1:0]     rad_r   [N];
  logic [VW-1:0]     res_r   [N];
  logic [SIDE_W-1:0] side_r  [N];

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic              v_in;
    logic [VW-1:0]     rad_in;
    logic [VW-1:0]     res_in;
    logic [SIDE_W-1:0] side_in;
    logic [VW-1:0]     bitv;
    logic [VW-1:0]     sum;
    logic              take;

    if (g == 0) begin : g_first
      assign v_in    = in_valid;
      assign rad_in  = in_rad;
      assign res_in  = '0;
      assign side_in = in_side;
    end else begin : g_rest
      assign v_in    = valid_r[g-1];
      assign rad_in  = rad_r[g-1];
      assign res_in  = res_r[g-1];
      assign side_in = side_r[g-1];
    end

    assign bitv = VW'(1) << (VW - 1 - 2 * g);
    assign sum  = res_in + bitv;
    assign take = rad_in >= sum;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[g] <= 1'b0;
      end else if (adv) begin
        valid_r[g] <= v_in;
      end
      if (adv) begin
        rad_r[g]  <= take ? rad_in - sum : rad_in;
        res_r[g]  <= take ? (res_in >> 1) + bitv : res_in >> 1;
        side_r[g] <= side_in;
      end
    end
  end

  assign out_valid = valid_r[N-1];
  assign out_root  = res_r[N-1][itcf_pkg::C_W-1:0];
  assign out_side  = side_r[N-1];
endmodule
`default_nettype wire

// ----- rtl/core/itcf_cf_term.sv -----
// One continued-fraction term: c = z*z*s / (2z+1+c) in Q5.26.
// Depends on itcf_pkg and itcf_div.
`default_nettype none
module itcf_cf_term #(
  parameter int Z      = 1,
  parameter int SIDE_W = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      adv,
  input  wire logic                      in_valid,
  input  wire logic [itcf_pkg::S_W-1:0]  in_s,
  input  wire logic [itcf_pkg::C_W-1:0]  in_c,
  input  wire logic [SIDE_W-1:0]         in_side,
  output logic                           out_valid,
  output logic [itcf_pkg::S_W-1:0]       out_s,
  output logic [itcf_pkg::C_W-1:0]       out_c,
  output logic [SIDE_W-1:0]              out_side
);
  localparam int NW = itcf_pkg::CF_NUM_W;
  localparam int DW = itcf_pkg::CF_DEN_W;
  localparam int SW = itcf_pkg::S_W;
  localparam int FR = itcf_pkg::FRAC_C;
  localparam logic [NW-1:0] ZSQ  = NW'(Z * Z);
  localparam logic [DW-1:0] BASE = DW'(2 * Z + 1) << FR;

  logic                 valid_r;
  logic [NW-1:0]        num_r;
  logic [DW-1:0]        den_r;
  logic [SW+SIDE_W-1:0] side_r;
  logic [SW+SIDE_W-1:0] div_side;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
    if (adv) begin
      num_r  <= NW'(in_s) * ZSQ;
      den_r  <= BASE + DW'(in_c);
      side_r <= {in_s, in_side};
    end
  end

  itcf_div #(
    .NUM_W (NW + FR),
    .DEN_W (DW),
    .Q_W   (itcf_pkg::C_W),
    .SIDE_W(SW + SIDE_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (valid_r),
    .in_num   ({num_r, {FR{1'b0}}}),
    .in_den   (den_r),
    .in_side  (side_r),
    .out_valid(out_valid),
    .out_q    (out_c),
    .out_side (div_side)
  );

  assign out_s    = div_side[SW+SIDE_W-1:SIDE_W];
  assign out_side = div_side[SIDE_W-1:0];
endmodule
`default_nettype wire

// ----- rtl/core/inverse_trig_continued_fraction.sv -----
// Inverse trigonometric unit: atan, atan2, asin and acos, Q16.16 in, Q3.29 out.
// Depends on itcf_pkg, itcf_sqrt, itcf_div, itcf_cf_term and the defines header.
//
// Input channel: in_tdata carries x_operand in bits 31:0 and y_operand in
// bits 63:32, in_tuser carries the function code (0 atan, 1 atan2, 2 asin,
// 3 acos). Output channel: out_tdata carries the angle in Q3.29 radians.
// Each input transfer yields exactly one output transfer, in order.
// The stages are: one operand stage, 32 square-root stages, one selection stage,
// 31 ratio-division stages, one squaring stage, 32 stages per continued-fraction
// term (a multiply stage and 31 division stages), 30 final-division stages and
// the output register.
// Throughput is one transfer per cycle while the receiver does not stall;
// the whole pipeline advances together.
// When the receiver stalls with a result held, every stage holds and
// in_tready drops; nothing is lost or repeated. Synchronous reset clears all
// valid bits, so the pipeline comes out of reset empty.
`default_nettype none
`include "inverse_trig_continued_fraction_defines.svh"
module inverse_trig_continued_fraction #(
  parameter int TERMS = itcf_pkg::TERMS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // x_operand[31:0], y_operand[63:32]
  input  wire logic [1:0]  in_tuser,   // func[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // angle[31:0]
);
  localparam int CTL_W = $bits(itcf_pkg::ctl_t);
  localparam int OW    = itcf_pkg::OPND_W;
  localparam int UW    = itcf_pkg::U_W;
  localparam int CW    = itcf_pkg::C_W;
  localparam int TW    = itcf_pkg::T_W;
  localparam int SW    = itcf_pkg::S_W;
  localparam int RW    = itcf_pkg::R_W;
  localparam int AW    = itcf_pkg::ANG_W;
  localparam int VW    = itcf_pkg::SQ_V_W;
  localparam int SQ_SIDE_W = CTL_W + UW + 2 * OW;
  localparam int CF_SIDE_W = CTL_W + TW;

  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // Operand stage.
  logic [OW-1:0] x_in, y_in, mx, my;
  logic [16:0]   axc;
  logic [33:0]   ax2;
  itcf_pkg::ctl_t in_ctl;

  assign x_in = in_tdata[31:0];
  assign y_in = in_tdata[63:32];
  assign mx   = x_in[OW-1] ? ~x_in + OW'(1) : x_in;
  assign my   = y_in[OW-1] ? ~y_in + OW'(1) : y_in;
  assign axc  = (mx > itcf_pkg::ONE_Q16) ? 17'h10000 : mx[16:0];
  assign ax2  = 34'(axc) * 34'(axc);

  always_comb begin
    in_ctl        = '0;
    in_ctl.func   = itcf_pkg::func_t'(in_tuser);
    in_ctl.x_neg  = x_in[OW-1];
    in_ctl.y_neg  = y_in[OW-1];
    in_ctl.x_zero = (x_in == '0);
    in_ctl.y_zero = (y_in == '0);
  end

  logic                 s0_v_r;
  logic [VW-1:0]        s0_rad_r;
  logic [SQ_SIDE_W-1:0] s0_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (adv) begin
      s0_v_r <= in_tvalid;
    end
    if (adv) begin
      s0_rad_r  <= (VW'(1) << 60) - (VW'(ax2) << 28);
      s0_side_r <= {in_ctl, {axc, 14'b0}, mx, my};
    end
  end

  // Cosine for asin and acos.
  logic                 sq_v;
  logic [CW-1:0]        sq_root;
  logic [SQ_SIDE_W-1:0] sq_side;

  itcf_sqrt #(.SIDE_W(SQ_SIDE_W)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (s0_v_r),
    .in_rad   (s0_rad_r),
    .in_side  (s0_side_r),
    .out_valid(sq_v),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  // Ratio selection and folding.
  itcf_pkg::ctl_t sq_ctl, sel_ctl_nxt;
  logic [UW-1:0]  sq_u;
  logic [OW-1:0]  sq_mx, sq_my, n_sel, d_sel;

  assign sq_ctl = itcf_pkg::ctl_t'(sq_side[SQ_SIDE_W-1:UW+2*OW]);
  assign sq_u   = sq_side[UW+2*OW-1:2*OW];
  assign sq_mx  = sq_side[2*OW-1:OW];
  assign sq_my  = sq_side[OW-1:0];

  always_comb begin
    unique case (sq_ctl.func)
      itcf_pkg::FN_ATAN: begin
        n_sel = sq_mx;
        d_sel = itcf_pkg::ONE_Q16;
      end
      itcf_pkg::FN_ATAN2: begin
        n_sel = sq_my;
        d_sel = (sq_mx == '0) ? OW'(1) : sq_mx;
      end
      default: begin
        n_sel = OW'(sq_u);
        d_sel = OW'(sq_root);
      end
    endcase
    sel_ctl_nxt        = sq_ctl;
    sel_ctl_nxt.fold   = n_sel > d_sel;
    sel_ctl_nxt.c_zero = (sq_root == '0);
  end

  logic           sel_v_r;
  logic [61:0]    sel_num_r;
  logic [OW-1:0]  sel_den_r;
  itcf_pkg::ctl_t sel_ctl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_v_r <= 1'b0;
    end else if (adv) begin
      sel_v_r <= sq_v;
    end
    if (adv) begin
      sel_num_r <= {(sel_ctl_nxt.fold ? d_sel : n_sel), 30'b0};
      sel_den_r <= sel_ctl_nxt.fold ? n_sel : d_sel;
      sel_ctl_r <= sel_ctl_nxt;
    end
  end

  // Folded ratio t in Q1.30.
  logic             ta_v;
  logic [TW-1:0]    ta_q;
  logic [CTL_W-1:0] ta_side;

  itcf_div #(.NUM_W(62), .DEN_W(OW), .Q_W(TW), .SIDE_W(CTL_W)) u_div_ratio (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (sel_v_r),
    .in_num   (sel_num_r),
    .in_den   (sel_den_r),
    .in_side  (sel_ctl_r),
    .out_valid(ta_v),
    .out_q    (ta_q),
    .out_side (ta_side)
  );

  // Square of t in Q1.26.
  logic [61:0]      t_sq;
  logic             sqr_v_r;
  logic [SW-1:0]    sqr_s_r;
  logic [CF_SIDE_W-1:0] sqr_side_r;

  assign t_sq = 62'(ta_q) * 62'(ta_q);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sqr_v_r <= 1'b0;
    end else if (adv) begin
      sqr_v_r <= ta_v;
    end
    if (adv) begin
      sqr_s_r    <= t_sq[60:34];
      sqr_side_r <= {ta_side, ta_q};
    end
  end

  // Continued fraction, deepest term first.
  logic                 cf_v    [TERMS+1];
  logic [SW-1:0]        cf_s    [TERMS+1];
  logic [CW-1:0]        cf_c    [TERMS+1];
  logic [CF_SIDE_W-1:0] cf_side [TERMS+1];

  assign cf_v[0]    = sqr_v_r;
  assign cf_s[0]    = sqr_s_r;
  assign cf_c[0]    = '0;
  assign cf_side[0] = sqr_side_r;

  for (genvar j = 0; j < TERMS; j++) begin : g_term
    itcf_cf_term #(.Z(TERMS - j), .SIDE_W(CF_SIDE_W)) u_term (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .in_valid (cf_v[j]),
      .in_s     (cf_s[j]),
      .in_c     (cf_c[j]),
      .in_side  (cf_side[j]),
      .out_valid(cf_v[j+1]),
      .out_s    (cf_s[j+1]),
      .out_c    (cf_c[j+1]),
      .out_side (cf_side[j+1])
    );
  end

  // atan(t) = t / (1 + c) in Q1.29.
  logic [TW-1:0]    cf_t;
  logic [CTL_W-1:0] cf_ctl;
  logic             fd_v;
  logic [RW-1:0]    fd_q;
  logic [CTL_W-1:0] fd_side;

  assign cf_t   = cf_side[TERMS][TW-1:0];
  assign cf_ctl = cf_side[TERMS][CF_SIDE_W-1:TW];

  itcf_div #(.NUM_W(TW + 25), .DEN_W(32), .Q_W(RW), .SIDE_W(CTL_W)) u_div_final (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (cf_v[TERMS]),
    .in_num   ({cf_t, 25'b0}),
    .in_den   ((32'd1 << itcf_pkg::FRAC_C) + 32'(cf_c[TERMS])),
    .in_side  (cf_ctl),
    .out_valid(fd_v),
    .out_q    (fd_q),
    .out_side (fd_side)
  );

  // Quadrant and function correction.
  itcf_pkg::ctl_t         fc;
  logic signed [AW-1:0]   a_s, a2, res;

  assign fc = itcf_pkg::ctl_t'(fd_side);

  always_comb begin
    a_s = fc.fold ? itcf_pkg::HALF_PI_Q29 - AW'(fd_q) : AW'(fd_q);
    a2  = a_s;
    res = a_s;
    unique case (fc.func)
      itcf_pkg::FN_ATAN: begin
        res = fc.x_neg ? -a_s : a_s;
      end
      itcf_pkg::FN_ATAN2: begin
        a2 = fc.x_neg ? itcf_pkg::PI_Q29 - a_s : a_s;
        if (fc.x_zero) begin
          res = fc.y_zero ? '0 : (fc.y_neg ? -itcf_pkg::HALF_PI_Q29 : itcf_pkg::HALF_PI_Q29);
        end else begin
          res = fc.y_neg ? -a2 : a2;
        end
      end
      default: begin
        a2  = fc.c_zero ? itcf_pkg::HALF_PI_Q29 : a_s;
        a2  = fc.x_neg ? -a2 : a2;
        res = (fc.func == itcf_pkg::FN_ACOS) ? itcf_pkg::HALF_PI_Q29 - a2 : a2;
      end
    endcase
  end

  logic        out_v_r;
  logic [31:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= fd_v;
    end
    if (adv) begin
      out_data_r <= res[31:0];
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  logic angle_ok;
  assign angle_ok = ($signed(out_tdata) <= 32'sd1686629713) &&
                    ($signed(out_tdata) >= -32'sd1686629713);

  `ITCF_ASSERT_IMPL(a_angle_range, out_tvalid, angle_ok)
  `ITCF_ASSERT_IMPL(a_ratio_le_one, ta_v, ta_q <= 31'h40000000)
  `ITCF_ASSERT_IMPL(a_cf_bound, cf_v[TERMS], cf_c[TERMS] <= 31'h40000000)
  `ITCF_ASSERT_NEXT(a_final_to_out, adv && fd_v, out_tvalid)
endmodule
`default_nettype wire
